@@ rtl/core/bad_port_set_unit_macros.svh @@
// assertion helpers for the bad port set unit
// each macro expects clk and rst_n in scope
`ifndef BAD_PORT_SET_UNIT_MACROS_SVH
`define BAD_PORT_SET_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define BPS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/bps_pkg.sv @@
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and command codes for the bad port set unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

  // command field
  localparam int CMD_WIDTH = 2;
  localparam logic [CMD_WIDTH-1:0] CMD_REPORT = 2'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_CLEAR  = 2'd2;

  // width of the entry count result field
  localparam int COUNT_OUT_WIDTH = 5;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  // table access strobes from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/bad_port_set_unit.sv @@
// Report and query on a non-empty table step through S_SCAN (the entries held,
// one per cycle through one comparator), S_DRAIN and S_FINISH; a report or query
// on an empty table, a clear and an unused command go straight to S_FINISH.
// One item is in flight at a time, and S_FINISH waits while out_ready stalls; in_ready is
// high only when idle. Reset (rst_n, synchronous, active low) empties the table
// and drops any pending result; table contents are not cleared.
// ----------------------------------------------------------------------------
// bad_port_set_unit
// Bounded table of ports reported as not found, with report, query and
// clear commands, scanned sequentially by a small sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bad_port_set_unit #(
  parameter int TABLE_DEPTH = 16,
  parameter int PORT_WIDTH  = 48
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [bps_pkg::CMD_WIDTH-1:0]    in_cmd,
  input  wire logic [PORT_WIDTH-1:0]            in_port_value,
  input  wire logic                             in_error_is_not_found,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_known_bad,
  output logic                                  out_newly_recorded,
  output logic                                  out_table_full,
  output logic [bps_pkg::COUNT_OUT_WIDTH-1:0]   out_entry_count
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int OW = bps_pkg::COUNT_OUT_WIDTH;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  bps_pkg::state_t state_r, state_nxt;
  logic [bps_pkg::CMD_WIDTH-1:0] cmd_r;
  logic [PORT_WIDTH-1:0]         port_r;
  logic                          nf_r;
  logic [CW-1:0]                 idx_r, idx_nxt;
  logic                          hit_r, hit_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_known_bad_r, out_known_bad_nxt;
  logic                          out_newly_r, out_newly_nxt;
  logic                          out_full_r, out_full_nxt;
  logic [OW-1:0]                 out_count_r, out_count_nxt;

  bps_pkg::mem_ctl_t ctl;
  logic              match_hit;
  logic              added;
  logic [CW+OW-1:0]  count_ext;

  // table and comparator
  bps_match #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (PORT_WIDTH),
    .IW    (IW)
  ) u_match (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .rd_addr (idx_r[IW-1:0]),
    .wr_addr (count_r[IW-1:0]),
    .wr_data (port_r),
    .key     (port_r),
    .hit     (match_hit)
  );

  assign in_ready = (state_r == bps_pkg::S_IDLE);
  assign count_ext = {{OW{1'b0}}, count_nxt};

  // sequencer next state and result
  always_comb begin
    state_nxt         = state_r;
    idx_nxt           = idx_r;
    hit_nxt           = hit_r | match_hit;
    count_nxt         = count_r;
    ctl               = '0;
    added             = 1'b0;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_known_bad_nxt = out_known_bad_r;
    out_newly_nxt     = out_newly_r;
    out_full_nxt      = out_full_r;
    out_count_nxt     = out_count_r;
    case (state_r)
      bps_pkg::S_IDLE: begin
        if (in_valid) begin
          hit_nxt = 1'b0;
          idx_nxt = '0;
          if ((in_cmd == bps_pkg::CMD_REPORT || in_cmd == bps_pkg::CMD_QUERY) &&
              count_r != '0) begin
            state_nxt = bps_pkg::S_SCAN;
          end else begin
            state_nxt = bps_pkg::S_FINISH;
          end
        end
      end
      bps_pkg::S_SCAN: begin
        ctl.rd_en = 1'b1;
        if (CW'(idx_r + CW'(1)) == count_r) begin
          state_nxt = bps_pkg::S_DRAIN;
        end else begin
          idx_nxt = CW'(idx_r + CW'(1));
        end
      end
      bps_pkg::S_DRAIN: begin
        state_nxt = bps_pkg::S_FINISH;
      end
      bps_pkg::S_FINISH: begin
        case (cmd_r)
          bps_pkg::CMD_REPORT: begin
            added = nf_r && !hit_r && (count_r < DEPTH_C);
            if (added) begin
              count_nxt = CW'(count_r + CW'(1));
            end
          end
          bps_pkg::CMD_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
          end
        endcase
        if (!out_valid_r || out_ready) begin
          ctl.wr_en         = added;
          state_nxt         = bps_pkg::S_IDLE;
          out_valid_nxt     = 1'b1;
          out_known_bad_nxt = hit_r;
          out_newly_nxt     = added;
          out_full_nxt      = (count_nxt == DEPTH_C);
          out_count_nxt     = count_ext[OW-1:0];
        end else begin
          count_nxt = count_r;
        end
      end
      default: begin
        state_nxt = bps_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bps_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      hit_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      hit_r       <= hit_nxt;
    end
  end

  // item capture on input transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r  <= in_cmd;
      port_r <= in_port_value;
      nf_r   <= in_error_is_not_found;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_known_bad_r <= out_known_bad_nxt;
    out_newly_r     <= out_newly_nxt;
    out_full_r      <= out_full_nxt;
    out_count_r     <= out_count_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_known_bad      = out_known_bad_r;
  assign out_newly_recorded = out_newly_r;
  assign out_table_full     = out_full_r;
  assign out_entry_count    = out_count_r;

  // checks
`include "bad_port_set_unit_macros.svh"

  `BPS_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= DEPTH_C, "entry count above table depth")
  `BPS_ASSERT_IMPL(a_scan_in_range, state_r == bps_pkg::S_SCAN, idx_r < count_r,
                   "scan index beyond stored entries")
  `BPS_ASSERT_IMPL(a_new_not_known, out_valid_r, !(out_known_bad_r && out_newly_r),
                   "port recorded although already stored")
  `BPS_ASSERT_NEXT(a_append_grows, ctl.wr_en, count_r == CW'($past(count_r) + CW'(1)),
                   "table write without count increment")

endmodule

`default_nettype wire

@@ rtl/core/bps_match.sv @@
// ----------------------------------------------------------------------------
// bps_match
// Port table storage with a registered read port and the shared equality
// comparator used by the scan sequencer, one entry per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bps_match #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 48,
  parameter int IW    = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bps_pkg::mem_ctl_t ctl,
  input  wire logic [IW-1:0]     rd_addr,
  input  wire logic [IW-1:0]     wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [WIDTH-1:0]  key,
  output logic                   hit
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;
  logic             rd_vld_r;

  // table write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // read data valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= ctl.rd_en;
    end
  end

  // shared comparator
  assign hit = rd_vld_r && (rd_data_r == key);

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for bad_port_set_unit. Directed and random report,
// query and clear traffic is sent through the input channel. A local table
// model predicts every result, and each result is checked field by field
// against the oldest prediction. The sender idles in bursts, and the result
// side stalls on a rotating pattern.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int TABLE_DEPTH = 16;
  localparam int PORT_WIDTH  = 48;
  localparam int CMD_W       = bps_pkg::CMD_WIDTH;
  localparam int COUNT_W     = bps_pkg::COUNT_OUT_WIDTH;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [PORT_WIDTH-1:0] PORT_ALL_ONES = '1;
  // drain margin after the last result, sized from the table depth
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;
  localparam int RANDOM_ITEMS = 560;

  typedef struct packed {
    logic               known_bad;
    logic               newly_recorded;
    logic               table_full;
    logic [COUNT_W-1:0] entry_count;
  } port_verdict_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CMD_W-1:0]      in_cmd = bps_pkg::CMD_REPORT;
  logic [PORT_WIDTH-1:0] in_port_value = '0;
  logic                  in_error_is_not_found = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_known_bad;
  logic                  out_newly_recorded;
  logic                  out_table_full;
  logic [COUNT_W-1:0]    out_entry_count;

  // local copy of the table
  logic [PORT_WIDTH-1:0] held_ports [TABLE_DEPTH];
  int unsigned           ports_held = 0;

  port_verdict_t port_verdicts [$];
  int unsigned   mismatch_count = 0;
  int unsigned   items_sent = 0;
  int unsigned   burst_left = 0;

  bad_port_set_unit #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .PORT_WIDTH (PORT_WIDTH)
  ) u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_cmd               (in_cmd),
    .in_port_value        (in_port_value),
    .in_error_is_not_found(in_error_is_not_found),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_known_bad        (out_known_bad),
    .out_newly_recorded   (out_newly_recorded),
    .out_table_full       (out_table_full),
    .out_entry_count      (out_entry_count)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // table model: lookup first, then append, clear or nothing
  function automatic port_verdict_t update_port_model(input logic [CMD_W-1:0] cmd,
                                                      input logic [PORT_WIDTH-1:0] port,
                                                      input logic not_found);
    port_verdict_t verdict;
    logic          hit;
    int unsigned   idx;
    verdict = '0;
    hit = 1'b0;
    if (cmd == bps_pkg::CMD_REPORT || cmd == bps_pkg::CMD_QUERY) begin
      for (idx = 0; idx < ports_held; idx++) begin
        if (held_ports[idx] == port) hit = 1'b1;
      end
    end
    if (cmd == bps_pkg::CMD_REPORT && not_found && !hit && ports_held < TABLE_DEPTH) begin
      held_ports[ports_held] = port;
      ports_held++;
      verdict.newly_recorded = 1'b1;
    end else if (cmd == bps_pkg::CMD_CLEAR) begin
      ports_held = 0;
    end
    verdict.known_bad = hit;
    verdict.table_full = (ports_held == TABLE_DEPTH);
    verdict.entry_count = COUNT_W'(ports_held);
    return verdict;
  endfunction

  // one line per mismatch
  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // random port, with the extremes now and then
  function automatic logic [PORT_WIDTH-1:0] random_port();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 15))
      0: return '0;
      1: return PORT_ALL_ONES;
      default: return raw[PORT_WIDTH-1:0];
    endcase
  endfunction

  // send one item and record its prediction at the transfer;
  // valid stays high into the next item unless a burst ends with an idle gap
  task automatic send_item(input logic [CMD_W-1:0] cmd,
                           input logic [PORT_WIDTH-1:0] port,
                           input logic not_found);
    int unsigned gap;
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_port_value <= port;
    in_error_is_not_found <= not_found;
    do @(posedge clk); while (!in_ready);
    port_verdicts.push_back(update_port_model(cmd, port, not_found));
    items_sent++;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 10);
    end else begin
      burst_left--;
    end
  endtask

  // result side stalls on a rotating pattern, reloaded from time to time
  logic [15:0] stall_pattern = 16'hFFFF;
  int unsigned pattern_age = 0;
  always @(posedge clk) begin
    if (pattern_age == 0) begin
      stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      pattern_age <= $urandom_range(32, 200);
    end else begin
      stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      pattern_age <= pattern_age - 1;
    end
    out_ready <= stall_pattern[0];
  end

  // check each result transfer against the oldest prediction
  always @(posedge clk) begin
    port_verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (port_verdicts.size() == 0) begin
        report_mismatch("result with no item pending");
      end else begin
        want = port_verdicts.pop_front();
        if (out_known_bad !== want.known_bad)
          report_mismatch($sformatf("known_bad: expected %0b got %0b",
                                    want.known_bad, out_known_bad));
        if (out_newly_recorded !== want.newly_recorded)
          report_mismatch($sformatf("newly_recorded: expected %0b got %0b",
                                    want.newly_recorded, out_newly_recorded));
        if (out_table_full !== want.table_full)
          report_mismatch($sformatf("table_full: expected %0b got %0b",
                                    want.table_full, out_table_full));
        if (out_entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count: expected %0d got %0d",
                                    want.entry_count, out_entry_count));
      end
    end
  end

  // empty table: miss, report without not-found, unused command
  task automatic test_empty_table();
    send_item(bps_pkg::CMD_QUERY, '0, 1'b1);
    send_item(bps_pkg::CMD_REPORT, PORT_ALL_ONES, 1'b0);
    send_item(CMD_UNUSED, PORT_ALL_ONES, 1'b1);
  endtask

  // fill to depth, then duplicate and new reports on a full table, query, unused command, clear
  task automatic test_fill_to_full();
    logic [PORT_WIDTH-1:0] port;
    int unsigned           idx;
    for (idx = 0; idx < TABLE_DEPTH; idx++) begin
      if (idx == 0) port = '0;
      else if (idx == 1) port = {(PORT_WIDTH/2){2'b01}};
      else if (idx == 2) port = {(PORT_WIDTH/2){2'b10}};
      else if (idx == TABLE_DEPTH - 1) port = PORT_ALL_ONES;
      else port = PORT_WIDTH'(1) << (idx * 3);
      send_item(bps_pkg::CMD_REPORT, port, 1'b1);
    end
    send_item(bps_pkg::CMD_REPORT, PORT_ALL_ONES, 1'b1);
    send_item(bps_pkg::CMD_REPORT, PORT_WIDTH'(2), 1'b1);
    send_item(bps_pkg::CMD_QUERY, {(PORT_WIDTH/2){2'b10}}, 1'b0);
    send_item(CMD_UNUSED, '0, 1'b0);
    send_item(bps_pkg::CMD_CLEAR, PORT_ALL_ONES, 1'b1);
  endtask

  // episodes that start with a clear and draw ports mostly from a small pool,
  // so hits, duplicates and full tables come up often
  task automatic test_random_traffic(input int unsigned num_items);
    logic [PORT_WIDTH-1:0] port_pool [24];
    logic [PORT_WIDTH-1:0] port;
    logic [CMD_W-1:0]      cmd;
    int unsigned           pool_size;
    int unsigned           episode_len;
    int unsigned           stop_at;
    int unsigned           pick;
    int unsigned           idx;
    stop_at = items_sent + num_items;
    while (items_sent < stop_at) begin
      pool_size = $urandom_range(4, 24);
      for (idx = 0; idx < pool_size; idx++) port_pool[idx] = random_port();
      episode_len = $urandom_range(4, 60);
      send_item(bps_pkg::CMD_CLEAR, random_port(), 1'($urandom));
      for (idx = 0; idx < episode_len; idx++) begin
        pick = $urandom_range(0, 99);
        if (pick < 58) cmd = bps_pkg::CMD_REPORT;
        else if (pick < 92) cmd = bps_pkg::CMD_QUERY;
        else if (pick < 95) cmd = bps_pkg::CMD_CLEAR;
        else cmd = CMD_UNUSED;
        port = ($urandom_range(0, 4) == 0) ? random_port()
                                           : port_pool[$urandom_range(0, pool_size - 1)];
        send_item(cmd, port, $urandom_range(0, 99) < 85);
      end
    end
  endtask

  // main sequence
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_fill_to_full();
    test_random_traffic(RANDOM_ITEMS);
    in_valid <= 1'b0;
    while (port_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/bps_pkg.sv
rtl/core/bps_match.sv
rtl/core/bad_port_set_unit.sv
verif/tb_top.sv
